[rtl/lrupr_pkg.sv]
// package for the lru page replacement core
// holds default sizes, configuration constants and the sequencer state type
// no dependencies
package lrupr_pkg;

  localparam int FRAMES_DEF = 32;
  localparam int PAGES_DEF  = 64;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

  localparam int FAULT_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

endpackage

[rtl/lrupr_cell.sv]
// one frame cell of the lru chain: page, valid bit and recency rank
// depends on lrupr_pkg; search and update types come from the top level
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int  FRAMES = FRAMES_DEF,
  parameter int  PAGES  = PAGES_DEF,
  parameter int  J      = 0,
  parameter type acc_t  = logic,
  parameter type upd_t  = logic
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(FRAMES+1)-1:0]  n,
  input  acc_t                         acc_in,
  output acc_t                         acc_out,
  input  upd_t                         upd
);

  localparam int IW = $clog2(FRAMES);
  localparam int NW = $clog2(FRAMES + 1);
  localparam int PW = $clog2(PAGES);
  localparam logic [IW-1:0] JI   = IW'(J);
  localparam logic [NW-1:0] JN   = NW'(J);
  localparam logic [IW-1:0] RMAX = IW'(FRAMES - 1);

  logic [PW-1:0] page;
  logic          valid;
  logic [IW-1:0] rank;
  logic          active;
  acc_t          acc_next;

  assign active = (JN < n);

  // fold this frame into the running search word
  always_comb begin
    acc_next = acc_in;
    if (active && valid && (page == acc_in.page) && !acc_in.found) begin
      acc_next.found    = 1'b1;
      acc_next.hit_idx  = JI;
      acc_next.hit_rank = rank;
    end
    if (active && !valid && !acc_in.empty) begin
      acc_next.empty     = 1'b1;
      acc_next.empty_idx = JI;
    end
    // first frame seeds the victim, later ones win only on a strictly older rank
    if (active && ((J == 0) || (rank > acc_in.best_rank))) begin
      acc_next.best_rank = rank;
      acc_next.best_idx  = JI;
      acc_next.best_page = page;
    end
  end

  always_ff @(posedge clk) begin
    acc_out <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.idx == JI) begin
        rank <= '0;
        if (upd.miss) begin
          valid <= 1'b1;
        end
      end else if (active && valid && (upd.lim_all || (rank < upd.limit)) &&
                   (rank != RMAX)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // page store, written only on a fill or replacement
  always_ff @(posedge clk) begin
    if (upd.en && upd.miss && (upd.idx == JI)) begin
      page <= upd.page;
    end
  end

endmodule

[rtl/lru_page_replacement_core.sv]
// lru page replacement core: a chain of frame cells swept by a search word
// flow: an accepted word is registered, swept down the chain cells, then loaded into the output register
// a new word is accepted only in idle, after the previous one has been loaded into the output register
// a finished result waits in the output register while the next word is accepted
// reset (rst, synchronous): all frames empty, ranks zero, fault count zero,
// frames_in_use back to 4; page stores are not cleared
module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int PAGES  = PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: frames_in_use
  input  logic                          cfg_we,
  input  logic [CFG_W-1:0]              cfg_wdata,
  // input word
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [$clog2(PAGES)-1:0]      page_number,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [$clog2(FRAMES)-1:0]     frame_index,
  output logic                          evicted_valid,
  output logic [$clog2(PAGES)-1:0]      evicted_page,
  output logic [FAULT_W-1:0]            fault_count
);

  localparam int IW = $clog2(FRAMES);
  localparam int NW = $clog2(FRAMES + 1);
  localparam int PW = $clog2(PAGES);
  localparam int MW = (NW > CFG_W) ? NW : CFG_W;

  // search word that travels down the chain, one cell per cycle
  typedef struct packed {
    logic [PW-1:0] page;
    logic          found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] hit_rank;
    logic          empty;
    logic [IW-1:0] empty_idx;
    logic [IW-1:0] best_rank;
    logic [IW-1:0] best_idx;
    logic [PW-1:0] best_page;
  } acc_t;

  // update broadcast to every cell at the end of the search
  typedef struct packed {
    logic          en;
    logic          miss;
    logic [IW-1:0] idx;
    logic [IW-1:0] limit;
    logic          lim_all;
    logic [PW-1:0] page;
  } upd_t;

  state_t           state;
  state_t           state_next;
  logic [IW-1:0]    cnt;
  logic [CFG_W-1:0] frames_in_use;
  logic [PW-1:0]    page_reg;
  logic [FAULT_W-1:0] faults;
  logic [FAULT_W-1:0] faults_next;

  logic [MW-1:0]    cfg_ext;
  logic [NW-1:0]    n_eff;
  logic             in_accept;
  logic             load;

  acc_t             head;
  acc_t             chain [FRAMES];
  acc_t             tail;
  upd_t             upd;
  logic             ev_valid;
  logic [PW-1:0]    ev_page;

  // effective frame count: zero acts as one, above FRAMES clamps to FRAMES
  always_comb begin
    cfg_ext = MW'(frames_in_use);
    if (cfg_ext == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > MW'(FRAMES)) begin
      n_eff = NW'(FRAMES);
    end else begin
      n_eff = NW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // search word entering the first cell
  always_comb begin
    head      = '0;
    head.page = page_reg;
  end

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      lrupr_cell #(
        .FRAMES (FRAMES),
        .PAGES  (PAGES),
        .J      (g),
        .acc_t  (acc_t),
        .upd_t  (upd_t)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .n       (n_eff),
        .acc_in  ((g == 0) ? head : chain[(g == 0) ? 0 : g - 1]),
        .acc_out (chain[g]),
        .upd     (upd)
      );
    end
  endgenerate

  assign tail = chain[FRAMES-1];

  // pick the frame: hit, else lowest empty, else oldest (lowest index on ties)
  always_comb begin
    upd      = '0;
    ev_valid = 1'b0;
    ev_page  = '0;
    upd.en   = load;
    upd.page = tail.page;
    if (tail.found) begin
      upd.idx   = tail.hit_idx;
      upd.limit = tail.hit_rank;
    end else if (tail.empty) begin
      upd.miss    = 1'b1;
      upd.idx     = tail.empty_idx;
      upd.lim_all = 1'b1;
    end else begin
      upd.miss  = 1'b1;
      upd.idx   = tail.best_idx;
      upd.limit = tail.best_rank;
      ev_valid  = 1'b1;
      ev_page   = tail.best_page;
    end
  end

  // saturating fault counter
  always_comb begin
    faults_next = faults;
    if (upd.miss && (faults != '1)) begin
      faults_next = faults + 1'b1;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (cnt == IW'(FRAMES - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!(out_valid && out_stall)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    load     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SEARCH: begin
        in_stall = 1'b1;
      end
      ST_UPDATE: begin
        // hold the result until the output register is free
        load = !(out_valid && out_stall);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      faults <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        cnt <= '0;
      end else if (state == ST_SEARCH) begin
        cnt <= cnt + 1'b1;
      end
      if (load) begin
        faults <= faults_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      page_reg <= page_number;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit           <= tail.found;
      frame_index   <= upd.idx;
      evicted_valid <= ev_valid;
      evicted_page  <= ev_page;
      fault_count   <= faults_next;
    end
  end

endmodule

[rtl/lrupr_checker.sv]
// port-level checks for the lru page replacement core, bound to the top level
// depends on lrupr_pkg
module lrupr_checker
  import lrupr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int PAGES  = PAGES_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      hit,
  input logic [$clog2(FRAMES)-1:0] frame_index,
  input logic                      evicted_valid,
  input logic [$clog2(PAGES)-1:0]  evicted_page,
  input logic [FAULT_W-1:0]        fault_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_index) &&
      $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_count))
    else $error("result word changed while stalled");

  // one word at a time: after an accept the input side stalls
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // a miss has always been counted
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> fault_count != '0)
    else $error("miss with zero fault count");

  // only a miss can evict
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  // evicted page reads zero when nothing was evicted
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement_core lrupr_checker #(
  .FRAMES (FRAMES),
  .PAGES  (PAGES)
) u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .hit           (hit),
  .frame_index   (frame_index),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_count   (fault_count)
);
